// ===== rtl/dds_sgn_pkg.sv =====
package dds_sgn_pkg;

    // Field and register widths
    localparam int SAMPLE_W     = 12;
    localparam int WORD_W       = 12;
    localparam int PHASE_STEP_W = 13;
    localparam int AMP_W        = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    // Output coding
    localparam int MID_CODE  = 2048;
    localparam int MAX_CODE  = 4095;
    localparam int SINE_PEAK = 1850;

    // Quadrature output bounds: +/- (255 * 1850 / 256) around mid scale
    localparam int QUAD_LOW  = 206;
    localparam int QUAD_HIGH = 3890;

    // Register reset values
    localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = PHASE_STEP_W'(524);
    localparam logic [AMP_W-1:0]        AMPLITUDE_RST  = AMP_W'(128);
    localparam logic [AMP_W-1:0]        NOISE_AMP_RST  = AMP_W'(0);

    // pi/2 in Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Input word kind, carried on tuser
    typedef enum logic {
        KIND_WORD = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_AMPLITUDE  = 2'd1,
        CFG_NOISE_AMP  = 2'd2
    } cfg_index_t;

    // (a*b) >> 62, elaboration only
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // trunc(SINE_PEAK * sin(r * (pi/2) / quarter)) by odd power series
    function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input int unsigned r,
                                                                 input int unsigned addr_bits);
        logic [63:0]  quarter;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  prod;
        int unsigned  n;
        quarter = 64'd1 << (addr_bits - 2);
        if (r == 0)
            return '0;
        if (64'(r) >= quarter)
            return SAMPLE_W'(SINE_PEAK);
        x    = (HALF_PI_Q62 >> (addr_bits - 2)) * 64'(r);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (n = 1; n <= 12; n++)
        begin
            term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        prod = (sum >> 20) * 64'(SINE_PEAK);
        return SAMPLE_W'(prod >> 42);
    endfunction

    // Full-period sine table entry
    function automatic logic signed [SAMPLE_W-1:0] rom_entry(input int unsigned i,
                                                              input int unsigned addr_bits);
        int unsigned                 quarter;
        int unsigned                 quad;
        int unsigned                 r;
        logic signed [SAMPLE_W-1:0]  v;
        quarter = 1 << (addr_bits - 2);
        quad    = (i >> (addr_bits - 2)) & 3;
        r       = i & (quarter - 1);
        if (quad == 0 || quad == 2)
            v = quarter_sine(r, addr_bits);
        else
            v = quarter_sine(quarter - r, addr_bits);
        return (quad >= 2) ? -v : v;
    endfunction

endpackage

// ===== rtl/dds_sine_with_gaussian_noise_top.sv =====
// Sine synthesiser with a quadrature companion and near-Gaussian noise.
//
// Input stream (s_*): s_tuser = 1 marks a sample tick, s_tuser = 0 a random
// word in s_tdata[11:0]. A random word replaces the oldest entry of the noise
// ring and gives no output. A tick advances the phase accumulator and yields
// one output word on m_*: main sample (sine plus scaled ring mean, clamped)
// in m_tdata[11:0], quadrature sample in m_tdata[23:12].
// Configuration (cfg_*): phase step, amplitude and noise amplitude, to be
// written only while the block is idle; the block itself does not enforce it.
// A tick passes through stage 1, stages 2 to 4 and the output register before
// it shows on m_*. Throughput: one word per cycle of either kind while the
// output does not stall, set by the two-port sine ROM and the read-modify-write
// of the noise ring, whose reads and writes never touch the same entry together.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost.
// Reset clears the phase, the ring (through per-entry valid bits, no sweep),
// the running sum and the pipeline, and loads the register defaults; the
// block takes words from the first cycle after reset.
module dds_sine_with_gaussian_noise_top #(
    parameter int PHASE_BITS      = 16,
    parameter int TABLE_ADDR_BITS = 12,
    parameter int NOISE_DEPTH     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [11:0] random_word, [15:12] zero
    input  logic        s_tuser,     // [0] kind
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [11:0] main_sample, [23:12] quadrature_sample
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int SW          = dds_sgn_pkg::SAMPLE_W;
    localparam int WW          = dds_sgn_pkg::WORD_W;
    localparam int TABLE_SIZE  = 1 << TABLE_ADDR_BITS;
    localparam int PTR_W       = $clog2(NOISE_DEPTH);
    localparam int SUM_W       = $clog2(NOISE_DEPTH * 4095 + 1);
    localparam int DIFF_W      = SUM_W + 1;
    localparam int MAG_W       = $clog2(NOISE_DEPTH * dds_sgn_pkg::MID_CODE + 1);
    localparam int RECIP_SHIFT = MAG_W + $clog2(NOISE_DEPTH);
    localparam int RECIP_W     = MAG_W + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam longint RECIP_INT =
        ((64'd1 << RECIP_SHIFT) + NOISE_DEPTH - 1) / NOISE_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
    localparam logic signed [DIFF_W-1:0] RING_MID =
        DIFF_W'(NOISE_DEPTH * dds_sgn_pkg::MID_CODE);
    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_OFS =
        TABLE_ADDR_BITS'(TABLE_SIZE / 4);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NOISE_DEPTH - 1);

    // Sine ROM contents, fixed at elaboration
    logic signed [SW-1:0] sine_rom [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_rom
        localparam logic signed [SW-1:0] ENTRY = dds_sgn_pkg::rom_entry(g, TABLE_ADDR_BITS);
        assign sine_rom[g] = ENTRY;
    end

    // Noise ring storage
    logic [WW-1:0]          ring_mem [NOISE_DEPTH];
    logic [NOISE_DEPTH-1:0] ring_valid_reg;

    // Configuration registers
    logic [dds_sgn_pkg::PHASE_STEP_W-1:0] phase_step_reg;
    logic [dds_sgn_pkg::AMP_W-1:0]        amplitude_reg;
    logic [dds_sgn_pkg::AMP_W-1:0]        noise_amp_reg;

    // Front end state
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic [SUM_W-1:0]           ring_sum_reg;
    logic [SUM_W-1:0]           ring_sum_next;
    logic [TABLE_ADDR_BITS-1:0] sin_addr;
    logic [TABLE_ADDR_BITS-1:0] cos_addr;
    logic                       advance;
    logic                       accept;
    logic                       is_tick;

    // Stage 1
    logic                       tick_s1_reg;
    logic                       word_s1_reg;
    logic [WW-1:0]              data_s1_reg;
    logic [PTR_W-1:0]           ptr_s1_reg;
    logic [WW-1:0]              ring_rd_s1_reg;
    logic                       ring_hit_s1_reg;
    logic signed [SW-1:0]       sin_s1_reg;
    logic signed [SW-1:0]       cos_s1_reg;
    logic [WW-1:0]              ring_old;

    // Stage 2
    logic                       tick_s2_reg;
    logic signed [SW+8:0]       sin_prod_s2_reg;
    logic signed [SW+8:0]       cos_prod_s2_reg;
    logic signed [DIFF_W-1:0]   diff_s2_reg;
    logic signed [SW+8:0]       sin_adj;
    logic signed [SW+8:0]       cos_adj;
    logic                       diff_neg;
    logic [DIFF_W-1:0]          diff_abs;

    // Stage 3
    logic                       tick_s3_reg;
    logic signed [SW:0]         sin_part_s3_reg;
    logic signed [SW:0]         cos_part_s3_reg;
    logic [PROD_W-1:0]          noise_prod_s3_reg;
    logic                       noise_neg_s3_reg;
    logic [SW-1:0]              noise_q;
    logic signed [SW:0]         noise_mean;

    // Stage 4
    logic                       tick_s4_reg;
    logic signed [SW:0]         sin_part_s4_reg;
    logic signed [SW:0]         cos_part_s4_reg;
    logic signed [SW+9:0]       noise_mul_s4_reg;
    logic signed [SW+9:0]       noise_adj;
    logic signed [SW+1:0]       noise_part;
    logic signed [SW+2:0]       main_sum;
    logic [SW-1:0]              main_clamped;

    // Output register
    logic                       out_valid_reg;
    logic [2*SW-1:0]            out_data_reg;

    // Handshake: the whole pipeline holds while a result waits
    assign advance  = !(out_valid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign is_tick  = (s_tuser == dds_sgn_pkg::KIND_TICK);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= dds_sgn_pkg::PHASE_STEP_RST;
            amplitude_reg  <= dds_sgn_pkg::AMPLITUDE_RST;
            noise_amp_reg  <= dds_sgn_pkg::NOISE_AMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dds_sgn_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                dds_sgn_pkg::CFG_AMPLITUDE:  amplitude_reg  <= cfg_data[dds_sgn_pkg::AMP_W-1:0];
                dds_sgn_pkg::CFG_NOISE_AMP:  noise_amp_reg  <= cfg_data[dds_sgn_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase accumulator and table addresses
    assign phase_next = phase_reg + PHASE_BITS'(phase_step_reg);

    if (PHASE_BITS >= TABLE_ADDR_BITS)
    begin : g_addr_top
        assign sin_addr = phase_next[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    end
    else
    begin : g_addr_pad
        assign sin_addr = {phase_next, {(TABLE_ADDR_BITS - PHASE_BITS){1'b0}}};
    end

    assign cos_addr = sin_addr + QUARTER_OFS;
    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);

    // Advance the phase on a tick, the ring pointer on a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (accept)
        begin
            if (is_tick)
                phase_reg <= phase_next;
            else
                ptr_reg <= ptr_next;
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_s1_reg <= 1'b0;
            word_s1_reg <= 1'b0;
        end
        else if (advance)
        begin
            tick_s1_reg <= accept && is_tick;
            word_s1_reg <= accept && !is_tick;
        end
    end

    // ROM and ring reads; a ring entry is rewritten only a full lap later,
    // so the read here never meets the write of stage 1
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_s1_reg      <= sine_rom[sin_addr];
            cos_s1_reg      <= sine_rom[cos_addr];
            ring_rd_s1_reg  <= ring_mem[ptr_reg];
            ring_hit_s1_reg <= ring_valid_reg[ptr_reg];
            data_s1_reg     <= s_tdata[WW-1:0];
            ptr_s1_reg      <= ptr_reg;
        end
    end

    // Ring write-back and running sum
    assign ring_old      = ring_hit_s1_reg ? ring_rd_s1_reg : '0;
    assign ring_sum_next = ring_sum_reg - SUM_W'(ring_old) + SUM_W'(data_s1_reg);

    always_ff @(posedge clk)
    begin
        if (advance && word_s1_reg)
            ring_mem[ptr_s1_reg] <= data_s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            ring_sum_reg   <= '0;
        end
        else if (advance && word_s1_reg)
        begin
            ring_valid_reg[ptr_s1_reg] <= 1'b1;
            ring_sum_reg               <= ring_sum_next;
        end
    end

    // Stage 2: amplitude products and ring offset from mid scale
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_prod_s2_reg <= $signed({1'b0, amplitude_reg}) * sin_s1_reg;
            cos_prod_s2_reg <= $signed({1'b0, amplitude_reg}) * cos_s1_reg;
            diff_s2_reg     <= $signed({1'b0, ring_sum_reg}) - RING_MID;
        end
    end

    // Stage 3: truncate products by 256, scale ring magnitude by 1/depth
    assign sin_adj  = sin_prod_s2_reg + (sin_prod_s2_reg[SW+8] ? (SW+9)'(255) : '0);
    assign cos_adj  = cos_prod_s2_reg + (cos_prod_s2_reg[SW+8] ? (SW+9)'(255) : '0);
    assign diff_neg = diff_s2_reg[DIFF_W-1];
    assign diff_abs = diff_neg ? DIFF_W'(-diff_s2_reg) : DIFF_W'(diff_s2_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_part_s3_reg   <= sin_adj[SW+8:8];
            cos_part_s3_reg   <= cos_adj[SW+8:8];
            noise_prod_s3_reg <= PROD_W'(diff_abs[MAG_W-1:0]) * PROD_W'(RECIP);
            noise_neg_s3_reg  <= diff_neg;
        end
    end

    // Stage 4: signed ring mean times noise amplitude
    assign noise_q    = noise_prod_s3_reg[RECIP_SHIFT +: SW];
    assign noise_mean = noise_neg_s3_reg ? -$signed({1'b0, noise_q}) : $signed({1'b0, noise_q});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_part_s4_reg  <= sin_part_s3_reg;
            cos_part_s4_reg  <= cos_part_s3_reg;
            noise_mul_s4_reg <= $signed({1'b0, noise_amp_reg}) * noise_mean;
        end
    end

    // Pipeline control for stages 2 to 4 and the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_s2_reg   <= 1'b0;
            tick_s3_reg   <= 1'b0;
            tick_s4_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tick_s2_reg   <= tick_s1_reg;
            tick_s3_reg   <= tick_s2_reg;
            tick_s4_reg   <= tick_s3_reg;
            out_valid_reg <= tick_s4_reg;
        end
    end

    // Output: add offset and noise, clamp the main sample
    assign noise_adj  = noise_mul_s4_reg + (noise_mul_s4_reg[SW+9] ? (SW+10)'(255) : '0);
    assign noise_part = noise_adj[SW+9:8];
    assign main_sum   = (SW+3)'(sin_part_s4_reg) + (SW+3)'(dds_sgn_pkg::MID_CODE)
                      + (SW+3)'(noise_part);

    always_comb
    begin
        if (main_sum < 0)
            main_clamped = '0;
        else if (main_sum > (SW+3)'(dds_sgn_pkg::MAX_CODE))
            main_clamped = SW'(dds_sgn_pkg::MAX_CODE);
        else
            main_clamped = main_sum[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {cos_part_s4_reg[SW-1:0] + SW'(dds_sgn_pkg::MID_CODE), main_clamped};
    end

endmodule

// ===== rtl/dds_sgn_checker.sv =====
module dds_sgn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    localparam int SW = dds_sgn_pkg::SAMPLE_W;

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Accept input whenever the receiver is ready
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with receiver ready");

    // Accept input whenever no result waits
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

    // Quadrature sample stays within the scaled sine swing
    a_quad_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*SW-1:SW] >= SW'(dds_sgn_pkg::QUAD_LOW))
                  && (m_tdata[2*SW-1:SW] <= SW'(dds_sgn_pkg::QUAD_HIGH)))
        else $error("quadrature sample outside sine swing");

endmodule

bind dds_sine_with_gaussian_noise_top dds_sgn_checker u_dds_sgn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
